@@ hw/rtl/lzwd_pkg.sv @@
// Shared types and constants for the LZW variable-width decoder.
package lzwd_pkg;

   localparam int LITERAL_CODES    = 256;
   localparam int MIN_WIDTH        = 9;
   localparam int MAX_WIDTH        = 10;
   localparam int BYTES_PER_RESULT = 16;
   localparam int CODE_LIMIT       = 1 << MAX_WIDTH;
   localparam int DICT_DEPTH       = CODE_LIMIT - LITERAL_CODES;
   localparam int STACK_DEPTH      = DICT_DEPTH + 2;
   localparam int DICT_AW          = $clog2(DICT_DEPTH);
   localparam int STACK_AW         = $clog2(STACK_DEPTH);
   localparam int QUEUE_DEPTH      = 2;

   typedef struct packed {
      logic [9:0] code_word;
      logic       stream_start;
   } req_type;

   typedef struct packed {
      logic [63:0] bytes_low;
      logic [63:0] bytes_high;
      logic [4:0]  byte_count;
      logic        last_of_code;
      logic [3:0]  next_code_width;
      logic        bad_code;
   } rsp_type;

   // Head of the item queue as seen by the back end.
   typedef struct packed {
      logic    valid;
      req_type item;
   } queue_head_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_ROOT,
      ST_POP_RD,
      ST_POP_WR,
      ST_SEND
   } back_state_type;

endpackage

@@ hw/rtl/lzwd_front.sv @@
// Front end: accepts code word transactions into a short queue.
module lzwd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lzwd_pkg::req_type       req_payload,
   output lzwd_pkg::queue_head_type head,
   input  logic                    pop
);

   lzwd_pkg::req_type slot_ff [lzwd_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, do_pop;

   assign req_ready = (count_ff != 2'(lzwd_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign do_pop    = pop && (count_ff != 2'd0);

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_payload;
      end
   end

endmodule

@@ hw/rtl/lzwd_back.sv @@
// Back end: dictionary walk, string reversal and result packing.
module lzwd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  lzwd_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output lzwd_pkg::rsp_type        rsp_payload
);

   localparam int SW = lzwd_pkg::STACK_AW;
   localparam int DW = lzwd_pkg::DICT_AW;

   lzwd_pkg::back_state_type state_ff, state_in;

   // dictionary entries: {prefix, suffix}
   logic [17:0] dict_mem [lzwd_pkg::DICT_DEPTH];
   logic [7:0]  stack_mem [lzwd_pkg::STACK_DEPTH];
   logic [17:0] dict_rd_ff;
   logic [7:0]  stack_rd_ff;
   logic [DW-1:0] dict_raddr;
   logic [DW-1:0] dict_waddr;
   logic          dict_we;
   logic [SW-1:0] stack_raddr;
   logic [7:0]    stack_wdata;
   logic          stack_we;

   logic [9:0]   prev_ff, prev_in;
   logic [7:0]   first_ff, first_in;
   logic [10:0]  nfc_ff, nfc_in;
   logic [3:0]   width_ff, width_in;
   logic         have_ff, have_in;
   logic [9:0]   code_ff, code_in;
   logic [9:0]   cur_ff, cur_in;
   logic [SW-1:0] sp_ff, sp_in;
   logic         kwk_ff, kwk_in;
   logic         bad_ff, bad_in;
   logic [127:0] acc_ff, acc_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic         rsp_valid_ff, rsp_valid_in;
   lzwd_pkg::rsp_type rsp_ff, rsp_in;

   // decode of the queue head
   logic [10:0] eff_nfc;
   logic [3:0]  eff_w;
   logic        eff_have;
   logic [10:0] mask;
   logic [9:0]  code;
   logic        is_esc, is_bad, is_kwk;
   logic [9:0]  walk_c;
   logic [9:0]  prefix;

   // byte gather
   logic        add_byte;
   logic [7:0]  new_byte;
   logic [4:0]  cnt_add;
   logic        group_full;
   logic        no_more;
   logic        out_free;

   always_comb begin
      eff_nfc  = head.item.stream_start ? 11'(lzwd_pkg::LITERAL_CODES) : nfc_ff;
      eff_w    = head.item.stream_start ? 4'(lzwd_pkg::MIN_WIDTH) : width_ff;
      eff_have = head.item.stream_start ? 1'b0 : have_ff;
      mask     = (11'd1 << eff_w) - 11'd1;
      code     = head.item.code_word & mask[9:0];
      is_esc   = (code == mask[9:0]) && (eff_w < 4'(lzwd_pkg::MAX_WIDTH));
      is_bad   = eff_have ? ({1'b0, code} > eff_nfc)
                          : (code >= 10'(lzwd_pkg::LITERAL_CODES));
      is_kwk   = ({1'b0, code} == eff_nfc);
      walk_c   = is_kwk ? prev_ff : code;
      prefix   = dict_rd_ff[17:8];
   end

   assign no_more  = (sp_ff == '0) && !kwk_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cnt_add  = cnt_ff + 5'd1;
   assign group_full = (cnt_add == 5'(lzwd_pkg::BYTES_PER_RESULT));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lzwd_pkg::ST_IDLE: begin
            if (head.valid) begin
               if (is_esc || is_bad || !eff_have) begin
                  state_in = lzwd_pkg::ST_SEND;
               end else if (walk_c >= 10'(lzwd_pkg::LITERAL_CODES)) begin
                  state_in = lzwd_pkg::ST_WALK;
               end else begin
                  state_in = lzwd_pkg::ST_ROOT;
               end
            end
         end
         lzwd_pkg::ST_WALK: begin
            if (prefix < 10'(lzwd_pkg::LITERAL_CODES)) begin
               state_in = lzwd_pkg::ST_ROOT;
            end
         end
         lzwd_pkg::ST_ROOT: state_in = lzwd_pkg::ST_POP_RD;
         lzwd_pkg::ST_POP_RD: begin
            if (sp_ff != '0) begin
               state_in = lzwd_pkg::ST_POP_WR;
            end else begin
               state_in = lzwd_pkg::ST_SEND;
            end
         end
         lzwd_pkg::ST_POP_WR: begin
            if (group_full || no_more) begin
               state_in = lzwd_pkg::ST_SEND;
            end else begin
               state_in = lzwd_pkg::ST_POP_RD;
            end
         end
         lzwd_pkg::ST_SEND: begin
            if (out_free) begin
               state_in = no_more ? lzwd_pkg::ST_IDLE : lzwd_pkg::ST_POP_RD;
            end
         end
         default: state_in = lzwd_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      prev_in      = prev_ff;
      first_in     = first_ff;
      nfc_in       = nfc_ff;
      width_in     = width_ff;
      have_in      = have_ff;
      code_in      = code_ff;
      cur_in       = cur_ff;
      sp_in        = sp_ff;
      kwk_in       = kwk_ff;
      bad_in       = bad_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      dict_raddr   = DW'(prefix - 10'(lzwd_pkg::LITERAL_CODES));
      dict_waddr   = DW'(nfc_ff - 11'(lzwd_pkg::LITERAL_CODES));
      dict_we      = 1'b0;
      stack_we     = 1'b0;
      stack_wdata  = dict_rd_ff[7:0];
      stack_raddr  = sp_ff - SW'(1);
      add_byte     = 1'b0;
      new_byte     = stack_rd_ff;

      unique case (state_ff)
         lzwd_pkg::ST_IDLE: begin
            dict_raddr = DW'(walk_c - 10'(lzwd_pkg::LITERAL_CODES));
            if (head.valid) begin
               pop      = 1'b1;
               nfc_in   = eff_nfc;
               width_in = is_esc ? eff_w + 4'd1 : eff_w;
               have_in  = eff_have;
               code_in  = code;
               cur_in   = walk_c;
               sp_in    = '0;
               kwk_in   = 1'b0;
               bad_in   = 1'b0;
               acc_in   = '0;
               cnt_in   = '0;
               if (is_esc) begin
                  // width escape: empty result
               end else if (is_bad) begin
                  bad_in = 1'b1;
               end else if (!eff_have) begin
                  acc_in   = {120'd0, code[7:0]};
                  cnt_in   = 5'd1;
                  prev_in  = code;
                  first_in = code[7:0];
                  have_in  = 1'b1;
               end else begin
                  kwk_in = is_kwk;
               end
            end
         end
         lzwd_pkg::ST_WALK: begin
            stack_we = 1'b1;
            sp_in    = sp_ff + SW'(1);
            cur_in   = prefix;
         end
         lzwd_pkg::ST_ROOT: begin
            stack_we    = 1'b1;
            stack_wdata = cur_ff[7:0];
            sp_in       = sp_ff + SW'(1);
            if (nfc_ff < 11'(lzwd_pkg::CODE_LIMIT)) begin
               dict_we = 1'b1;
               nfc_in  = nfc_ff + 11'd1;
            end
            prev_in  = code_ff;
            first_in = cur_ff[7:0];
         end
         lzwd_pkg::ST_POP_RD: begin
            if (sp_ff != '0) begin
               sp_in = sp_ff - SW'(1);
            end else begin
               // KwKwK tail: the first byte once more
               add_byte = 1'b1;
               new_byte = first_ff;
               kwk_in   = 1'b0;
            end
         end
         lzwd_pkg::ST_POP_WR: begin
            add_byte = 1'b1;
         end
         lzwd_pkg::ST_SEND: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_in.bytes_low        = acc_ff[63:0];
               rsp_in.bytes_high       = acc_ff[127:64];
               rsp_in.byte_count       = cnt_ff;
               rsp_in.last_of_code     = no_more;
               rsp_in.next_code_width  = width_ff;
               rsp_in.bad_code         = bad_ff;
               acc_in                  = '0;
               cnt_in                  = '0;
            end
         end
         default: ;
      endcase

      if (add_byte) begin
         acc_in[cnt_ff[3:0]*8 +: 8] = new_byte;
         cnt_in                     = cnt_add;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzwd_pkg::ST_IDLE;
         prev_ff      <= '0;
         first_ff     <= '0;
         nfc_ff       <= 11'(lzwd_pkg::LITERAL_CODES);
         width_ff     <= 4'(lzwd_pkg::MIN_WIDTH);
         have_ff      <= 1'b0;
         sp_ff        <= '0;
         kwk_ff       <= 1'b0;
         bad_ff       <= 1'b0;
         cnt_ff       <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         first_ff     <= first_in;
         nfc_ff       <= nfc_in;
         width_ff     <= width_in;
         have_ff      <= have_in;
         sp_ff        <= sp_in;
         kwk_ff       <= kwk_in;
         bad_ff       <= bad_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      cur_ff  <= cur_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (dict_we) begin
         dict_mem[dict_waddr] <= {prev_ff, cur_ff[7:0]};
      end
      dict_rd_ff <= dict_mem[dict_raddr];
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[sp_ff] <= stack_wdata;
      end
      stack_rd_ff <= stack_mem[stack_raddr];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ hw/rtl/lzw_variable_width_decoder.sv @@
// Top level of the LZW variable-width decoder.
// Code words enter a two-entry queue and are decoded one at a time. A code
// is first classified, then its prefix chain is walked one dictionary entry
// at a time down to the root, then its bytes are popped from the reversal
// stack through the POP_RD and POP_WR states (plus the trailing byte of a
// repeated-string code) and sent in result groups of up to 16 bytes; an
// escape, a rejected code or a first literal goes from classification
// straight to send. The sequence is shaped by the registered reads of the
// dictionary and reversal-stack memories: each chain step and each popped
// byte waits for its read data. A stalled result holds the decoder in SEND.
// next_code_width on every result is the width for the following code word.
module lzw_variable_width_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lzwd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lzwd_pkg::rsp_type rsp_payload
);

   lzwd_pkg::queue_head_type head;
   logic pop;

   lzwd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .head        (head),
      .pop         (pop)
   );

   lzwd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ hw/rtl/lzwd_checker.sv @@
// Port-level checks for the LZW decoder, bound to the top level.
module lzwd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lzwd_pkg::rsp_type rsp_payload
);

   a_bad_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.bad_code |->
         rsp_payload.byte_count == 5'd0 && rsp_payload.last_of_code)
      else $error("bad code result carries bytes");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.byte_count <= 5'(lzwd_pkg::BYTES_PER_RESULT))
      else $error("byte count out of range");

   a_partial_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.byte_count != 5'(lzwd_pkg::BYTES_PER_RESULT) |->
         rsp_payload.last_of_code)
      else $error("partial group not last of code");

   a_width_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.next_code_width >= 4'(lzwd_pkg::MIN_WIDTH) &&
         rsp_payload.next_code_width <= 4'(lzwd_pkg::MAX_WIDTH))
      else $error("code width out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

endmodule

bind lzw_variable_width_decoder lzwd_checker u_lzwd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the LZW variable-width decoder.
`timescale 1ns / 1ps

module tb_top;

   typedef struct {
      lzwd_pkg::req_type item;
      bit      drain;   // hold this transaction until all results are back
   } pend_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   lzwd_pkg::req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   lzwd_pkg::rsp_type rsp_payload;

   lzw_variable_width_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   // decoder state as predicted
   logic [9:0]  dict_prefix [lzwd_pkg::DICT_DEPTH];
   logic [7:0]  dict_suffix [lzwd_pkg::DICT_DEPTH];
   int unsigned prev_code, free_code, cur_width;
   bit          have_prev;

   // generator shadow of the dictionary fill
   int unsigned gen_free, gen_width;
   bit          gen_have;

   pend_type pend_q[$];
   lzwd_pkg::rsp_type decoded_q[$];
   int       errors, codes_in, groups_out, bad_seen, escapes_seen, kwk_seen, longest;
   int       gap, burst, stall_mode, stall_left;
   bit       stim_done;

   function automatic void push_group(logic [63:0] lo, logic [63:0] hi, int cnt,
                                      bit last, bit bad);
      lzwd_pkg::rsp_type o;
      o.bytes_low = lo;
      o.bytes_high = hi;
      o.byte_count = cnt[4:0];
      o.last_of_code = last;
      o.next_code_width = cur_width[3:0];
      o.bad_code = bad;
      decoded_q.push_back(o);
   endfunction

   function automatic void decode_code(lzwd_pkg::req_type r);
      int unsigned all1, c, t, pos, cnt;
      logic [7:0]  root;
      logic [7:0]  str[$];
      logic [63:0] lo, hi;
      codes_in++;
      if (r.stream_start) begin
         free_code = lzwd_pkg::LITERAL_CODES;
         cur_width = lzwd_pkg::MIN_WIDTH;
         have_prev = 1'b0;
      end
      all1 = (1 << cur_width) - 1;
      c = r.code_word & all1;
      if (c == all1 && cur_width < lzwd_pkg::MAX_WIDTH) begin
         cur_width++;
         escapes_seen++;
         push_group('0, '0, 0, 1'b1, 1'b0);
         return;
      end
      if (!have_prev) begin
         if (c >= lzwd_pkg::LITERAL_CODES) begin
            bad_seen++;
            push_group('0, '0, 0, 1'b1, 1'b1);
            return;
         end
         prev_code = c;
         have_prev = 1'b1;
         push_group({56'd0, c[7:0]}, '0, 1, 1'b1, 1'b0);
         return;
      end
      if (c > free_code) begin
         bad_seen++;
         push_group('0, '0, 0, 1'b1, 1'b1);
         return;
      end
      t = (c < free_code) ? c : prev_code;
      while (t >= lzwd_pkg::LITERAL_CODES) begin
         str.push_front(dict_suffix[t - lzwd_pkg::LITERAL_CODES]);
         t = dict_prefix[t - lzwd_pkg::LITERAL_CODES];
      end
      root = t[7:0];
      str.push_front(root);
      if (c == free_code) begin
         str.push_back(root);
         kwk_seen++;
      end
      if (free_code < lzwd_pkg::CODE_LIMIT) begin
         dict_prefix[free_code - lzwd_pkg::LITERAL_CODES] = prev_code[9:0];
         dict_suffix[free_code - lzwd_pkg::LITERAL_CODES] = root;
         free_code++;
      end
      prev_code = c;
      if (str.size() > longest) longest = str.size();
      pos = 0;
      while (pos < str.size()) begin
         cnt = str.size() - pos;
         if (cnt > lzwd_pkg::BYTES_PER_RESULT) cnt = lzwd_pkg::BYTES_PER_RESULT;
         lo = '0;
         hi = '0;
         for (int i = 0; i < cnt; i++) begin
            if (i < 8) lo[8*i +: 8] = str[pos + i];
            else hi[8*(i-8) +: 8] = str[pos + i];
         end
         pos += cnt;
         push_group(lo, hi, cnt, pos >= str.size(), 1'b0);
      end
   endfunction

   // queue one code and track what the dictionary will look like
   function automatic void queue_code(int unsigned code, bit start, bit drain = 0);
      pend_type p;
      int unsigned all1, c;
      if (start) begin
         gen_free = lzwd_pkg::LITERAL_CODES;
         gen_width = lzwd_pkg::MIN_WIDTH;
         gen_have = 1'b0;
      end
      all1 = (1 << gen_width) - 1;
      c = code & all1;
      if (c == all1 && gen_width < lzwd_pkg::MAX_WIDTH) gen_width++;
      else if (!gen_have) gen_have = (c < lzwd_pkg::LITERAL_CODES);
      else if (c <= gen_free && gen_free < lzwd_pkg::CODE_LIMIT) gen_free++;
      p.item.code_word = code[9:0];
      p.item.stream_start = start;
      p.drain = drain;
      pend_q.push_back(p);
   endfunction

   function automatic void queue_random(bit drain);
      int unsigned sel, code, top, all1;
      bit          start;
      sel = $urandom_range(0, 99);
      start = 1'b0;
      all1 = (1 << gen_width) - 1;
      top = (gen_free < all1) ? gen_free : all1 - 1;
      if (sel < 3) begin
         start = 1'b1;
         code = $urandom_range(0, 255) | ($urandom_range(0, 1) << 9);
      end else if (sel < 4) begin
         start = 1'b1;
         code = $urandom_range(256, 1023);
      end else if (sel < 7 && gen_width < lzwd_pkg::MAX_WIDTH) begin
         code = all1 | ($urandom_range(0, 1) << 9);
      end else if (sel < 11) begin
         code = $urandom_range(0, 1023);
      end else if (!gen_have || sel < 25) begin
         code = $urandom_range(0, 255);
      end else if (sel < 50) begin
         code = top;
      end else if (sel < 80) begin
         code = (top >= lzwd_pkg::LITERAL_CODES + 4) ? top - $urandom_range(1, 4) : top;
      end else begin
         code = $urandom_range(0, top);
      end
      if (gen_width < lzwd_pkg::MAX_WIDTH && !(sel < 11 && sel >= 7))
         code = (code & all1) | ($urandom_range(0, 1) << 9);
      queue_code(code, start, drain);
   endfunction

   initial begin
      errors = 0;
      free_code = lzwd_pkg::LITERAL_CODES;
      cur_width = lzwd_pkg::MIN_WIDTH;
      have_prev = 1'b0;
      prev_code = 0;
      gen_free = lzwd_pkg::LITERAL_CODES;
      gen_width = lzwd_pkg::MIN_WIDTH;
      gen_have = 1'b0;
      // directed: literal extremes, repeated-string case, rejects, escapes
      queue_code(300, 1);            // first code not a literal
      queue_code(0, 1);
      queue_code(255, 0);
      queue_code(257, 0);            // equals next free code
      queue_code(258, 0);
      queue_code(259, 0);
      queue_code(262, 0);            // above next free code
      queue_code(256, 0);
      queue_code(1023, 0);           // escape with the upper bit set
      queue_code(1023, 0);           // all ones at full width: rejected
      queue_code(263, 0);
      queue_code(264, 0);
      queue_code(265, 0);
      queue_code(511, 1);            // escape as the first code
      queue_code(1012, 0);           // upper bits kept at full width: rejected
      queue_code(128, 0);
      queue_code(256, 0);
      queue_code(256, 0);
      queue_code(512 | 77, 1);       // upper bit masked at narrow width
      queue_code(0, 0, 1);
      for (int i = 0; i < 330; i++) begin
         if (i % 40 == 0 && $urandom_range(0, 1)) queue_code($urandom_range(0, 255), 1);
         queue_random(i % 110 == 55);
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pend_q.size() == 0 && !req_valid);
      wait (decoded_q.size() == 0);
      repeat (200) @(posedge clock);
      $display("%0d codes decoded into %0d result groups; longest string %0d bytes",
               codes_in, groups_out, longest);
      $display("%0d escapes, %0d rejected codes, %0d repeated-string codes",
               escapes_seen, bad_seen, kwk_seen);
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout at %0t, %0d results outstanding", $realtime, decoded_q.size());
      $display("end of test: mismatches");
      $finish;
   end

   // request driver: bursts with random gaps, optional drain pause
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap <= 0;
         burst <= $urandom_range(1, 12);
      end else begin
         if (req_valid && req_ready) decode_code(req_payload);
         if (!req_valid || req_ready) begin
            if (gap > 0) begin
               gap <= gap - 1;
               req_valid <= 1'b0;
            end else if (pend_q.size() == 0 ||
                         (pend_q[0].drain && decoded_q.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               req_payload <= pend_q[0].item;
               req_valid <= 1'b1;
               void'(pend_q.pop_front());
               if (burst <= 1) begin
                  burst <= $urandom_range(1, 20);
                  gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
               end else begin
                  burst <= burst - 1;
               end
            end
         end
      end
   end

   // result monitor with its own stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_mode <= 0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            groups_out++;
            if (decoded_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected transaction %p", $realtime, rsp_payload);
            end else if (rsp_payload !== decoded_q[0]) begin
               errors++;
               $display("%0t: mismatch expected %p actual %p", $realtime,
                        decoded_q[0], rsp_payload);
               void'(decoded_q.pop_front());
            end else begin
               void'(decoded_q.pop_front());
            end
         end
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(10, 80);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= ($urandom_range(0, 4) == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

endmodule

@@ sim.f @@
hw/rtl/lzwd_pkg.sv
hw/rtl/lzwd_front.sv
hw/rtl/lzwd_back.sv
hw/rtl/lzw_variable_width_decoder.sv
hw/rtl/lzwd_checker.sv
tb/tb_top.sv
